// ===== rtl/core/staircase_search_sorted_matrix_top_defines.svh =====
// ---------------------------------------------------------------------------
// Staircase search assertion macros
// These are the concurrent assertion forms used by the controller of the
// staircase search block.
// ---------------------------------------------------------------------------
`ifndef STAIRCASE_SEARCH_SORTED_MATRIX_TOP_DEFINES_SVH
`define STAIRCASE_SEARCH_SORTED_MATRIX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssm_pkg.sv =====
// ---------------------------------------------------------------------------
// Staircase search package
// Shared constants, codes and the command and status types that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package ssm_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;
  localparam int CFG_W        = 5;
  localparam int IDX_W        = 4;
  localparam int DATA_W       = 32;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic start;
    logic mem_wr;
    logic step;
    logic out_load;
    logic out_found;
    logic out_is_search;
  } ssm_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic leave;
  } ssm_sts_t;

endpackage

// ===== rtl/core/ssm_datapath.sv =====
// ---------------------------------------------------------------------------
// Staircase search datapath
// Holds the configuration registers, the matrix memory, the walk position
// and the result register, and reports compare outcomes to the controller.
// ---------------------------------------------------------------------------
module ssm_datapath #(
  parameter int MAX_ROWS = ssm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ssm_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ssm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssm_pkg::CFG_W-1:0]           cfg_data,
  input  logic [ssm_pkg::IDX_W-1:0]           row_index,
  input  logic [ssm_pkg::IDX_W-1:0]           col_index,
  input  logic signed [ssm_pkg::DATA_W-1:0]   entry_value,
  input  logic signed [ssm_pkg::DATA_W-1:0]   target,
  input  ssm_pkg::ssm_cmd_t                   cmd,
  output ssm_pkg::ssm_sts_t                   sts,
  output logic                                found,
  output logic                                is_search
);
  import ssm_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  logic [CFG_W-1:0]        rows_in_use;
  logic [CFG_W-1:0]        cols_in_use;
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] target_q;
  logic [RCNT_W-1:0]       r;
  logic [CCNT_W-1:0]       c;
  logic [RCNT_W-1:0]       nrows;
  logic [CCNT_W-1:0]       ncols;
  logic [RCNT_W-1:0]       r_next;
  logic [CCNT_W-1:0]       c_next;
  logic [CCNT_W-1:0]       c_cur_col;
  logic [CCNT_W-1:0]       c_next_col;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic                    wr_in_range;
  logic                    less;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [RIDX_W-1:0] rr,
                                                input logic [CIDX_W-1:0] cc);
    mk_addr = ADDR_W'(rr * MAX_COLS) + ADDR_W'(cc);
  endfunction

  always_comb begin
    nrows = (32'(rows_in_use) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(rows_in_use);
    ncols = (32'(cols_in_use) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(cols_in_use);
  end

  always_comb begin
    less       = target_q < rdata;
    r_next     = less ? r : r + RCNT_W'(1);
    c_next     = less ? c - CCNT_W'(1) : c;
    c_cur_col  = c - CCNT_W'(1);
    c_next_col = c_next - CCNT_W'(1);
    sts.empty  = (nrows == '0) || (ncols == '0);
    sts.hit    = target_q == rdata;
    sts.leave  = (r_next == nrows) || (c_next == '0);
    if (cmd.step) begin
      rd_addr = mk_addr(r_next[RIDX_W-1:0], c_next_col[CIDX_W-1:0]);
    end else begin
      rd_addr = mk_addr(r[RIDX_W-1:0], c_cur_col[CIDX_W-1:0]);
    end
    wr_in_range = (32'(row_index) < MAX_ROWS) && (32'(col_index) < MAX_COLS);
    wr_addr     = mk_addr(RIDX_W'(row_index), CIDX_W'(col_index));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_W'(MAX_ROWS_DEF);
      cols_in_use <= CFG_W'(MAX_COLS_DEF);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        CFG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_in_range) begin
      mem[wr_addr] <= entry_value;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r        <= '0;
      c        <= ncols;
      target_q <= target;
    end else if (cmd.step) begin
      r <= r_next;
      c <= c_next;
    end
    if (cmd.out_load) begin
      found     <= cmd.out_found;
      is_search <= cmd.out_is_search;
    end
  end

endmodule

// ===== rtl/core/ssm_controller.sv =====
// ---------------------------------------------------------------------------
// Staircase search controller
// Sequences each transaction, walking the matrix for a search, and hands the
// result to the output register once it is free.
// ---------------------------------------------------------------------------
`include "staircase_search_sorted_matrix_top_defines.svh"

module ssm_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  output logic              out_valid,
  input  logic              out_ready,
  output ssm_pkg::ssm_cmd_t cmd,
  input  ssm_pkg::ssm_sts_t sts
);
  import ssm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   pend_found;
  logic   pend_found_next;
  logic   pend_search;
  logic   pend_search_next;
  logic   in_accept;
  logic   slot_free;

  assign in_ready  = state == S_IDLE;
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    pend_found_next  = pend_found;
    pend_search_next = pend_search;
    out_valid_next   = out_valid && !out_ready;
    cmd              = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (func == FUNC_WRITE) begin
            cmd.mem_wr       = 1'b1;
            pend_found_next  = 1'b0;
            pend_search_next = 1'b0;
            state_next       = S_FINISH;
          end else begin
            cmd.start        = 1'b1;
            pend_found_next  = 1'b0;
            pend_search_next = 1'b1;
            state_next       = sts.empty ? S_FINISH : S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.hit) begin
          pend_found_next = 1'b1;
          state_next      = S_FINISH;
        end else if (sts.leave) begin
          state_next = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load      = 1'b1;
          cmd.out_found     = pend_found;
          cmd.out_is_search = pend_search;
          out_valid_next    = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    pend_found  <= pend_found_next;
    pend_search <= pend_search_next;
  end

  `SSM_ASSERT_SAME(a_no_overwrite, clk, rst, cmd.out_load, slot_free,
    "result register loaded while a result is still pending")
  `SSM_ASSERT_NEXT(a_finish_delivers, clk, rst, (state == S_FINISH) && slot_free,
    out_valid && (state == S_IDLE), "finished transaction not presented")
  `SSM_ASSERT_NEXT(a_write_finishes, clk, rst, in_accept && (func == FUNC_WRITE),
    (state == S_FINISH) && !pend_search, "write transaction not acknowledged")
  `SSM_ASSERT_NEXT(a_load_then_walk, clk, rst, state == S_LOAD, state == S_WALK,
    "first read not followed by the walk")

endmodule

// ===== rtl/core/staircase_search_sorted_matrix_top.sv =====
// Sequencing: a write passes through the finish state before its acknowledge;
// a search passes through the load, walk and finish states, the walk visiting
// one entry per cycle through the single registered memory read port.
// Throughput: one transaction at a time; the next is accepted once the result
// reaches the output register, which may still wait to be taken.
// Reset: synchronous, clears control state; region registers return to 16.
// ---------------------------------------------------------------------------
// Staircase search over a sorted matrix
// Stores signed entries by row and column and searches the region in use
// from its top-right corner, moving left or down on each comparison.
// ---------------------------------------------------------------------------
module staircase_search_sorted_matrix_top #(
  parameter int MAX_ROWS = ssm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ssm_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ssm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [ssm_pkg::IDX_W-1:0]         row_index,
  input  logic [ssm_pkg::IDX_W-1:0]         col_index,
  input  logic signed [ssm_pkg::DATA_W-1:0] entry_value,
  input  logic signed [ssm_pkg::DATA_W-1:0] target,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic                              is_search
);
  import ssm_pkg::*;

  ssm_cmd_t cmd;
  ssm_sts_t sts;

  ssm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ssm_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .row_index   (row_index),
    .col_index   (col_index),
    .entry_value (entry_value),
    .target      (target),
    .cmd         (cmd),
    .sts         (sts),
    .found       (found),
    .is_search   (is_search)
  );

endmodule
